@@ hdl/hpdt_pkg.sv @@
package hpdt_pkg;

  // Integrator width (signed)
  localparam int INTEGRAL_BITS = 48;

  // Shared multiplier: 17-bit signed A operand, B wide enough for the floored integral
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = (INTEGRAL_BITS - 15 > 33) ? INTEGRAL_BITS - 15 : 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Accumulator holds the loop sum and the final thrust sum
  localparam int ACC_W = (MUL_P_W + 2 > 60) ? MUL_P_W + 2 : 60;

  // Integrator add width
  localparam int SUM_W = ((INTEGRAL_BITS > MUL_P_W) ? INTEGRAL_BITS : MUL_P_W) + 1;

  // Field widths
  localparam int ERR_W     = 18;
  localparam int GAIN_W    = 16;
  localparam int THRUST_W  = 17;
  localparam int HEAD_W    = 16;
  localparam int TARGET_W  = 17;
  localparam int CMD_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Loop sum is held to +/- 2^40, so it fits a 42-bit signed register
  localparam int LOOP_LIM_BIT = 40;
  localparam int S_W          = LOOP_LIM_BIT + 2;
  localparam int S_HALF       = S_W / 2;

  // Angle and thrust constants
  localparam int HALF_TURN  = 23040;
  localparam int FULL_TURN  = 46080;
  localparam int THRUST_ONE = 32768;

  // Floor shifts
  localparam int INT_SHIFT = 16;
  localparam int OUT_SHIFT = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_OVERALL      = 3'd0,
    REG_GAIN_PROPORTIONAL = 3'd1,
    REG_GAIN_INTEGRAL     = 3'd2,
    REG_GAIN_DERIVATIVE   = 3'd3,
    REG_THRUST_SUM        = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_EDT,
    ST_INTEG,
    ST_KD,
    ST_KI,
    ST_SUM,
    ST_CLAMP,
    ST_KGLO,
    ST_KGHI,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MSEL_E_DT,
    MSEL_KP_E,
    MSEL_KD_RATE,
    MSEL_KI_INT,
    MSEL_KG_SLO,
    MSEL_KG_SHI
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_PROD,
    ACC_ADD_PROD,
    ACC_LOAD_THRUST,
    ACC_ADD_PROD_HI
  } acc_op_t;

  typedef struct packed {
    logic     ready;
    logic     load_err;
    logic     upd_integ;
    mul_sel_t msel;
    acc_op_t  acc_op;
    logic     load_s;
    logic     load_out;
  } hpdt_ctl_t;

endpackage

@@ hdl/hpdt_if.sv @@
interface hpdt_tick_if;
  import hpdt_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [HEAD_W-1:0]   measured_heading;
  logic signed [15:0]         rate_term;
  logic        [15:0]         elapsed_time;
  logic                       target_valid;
  logic signed [TARGET_W-1:0] target_heading;

  modport source (
    output valid, measured_heading, rate_term, elapsed_time, target_valid, target_heading,
    input  ready
  );
  modport sink (
    input  valid, measured_heading, rate_term, elapsed_time, target_valid, target_heading,
    output ready
  );
endinterface

interface hpdt_cmd_if;
  import hpdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] starboard_cmd;
  logic [CMD_W-1:0] port_side_cmd;
  logic             integrator_saturated;

  modport source (
    output valid, starboard_cmd, port_side_cmd, integrator_saturated,
    input  ready
  );
  modport sink (
    input  valid, starboard_cmd, port_side_cmd, integrator_saturated,
    output ready
  );
endinterface

@@ hdl/hpdt_mul.sv @@
module hpdt_mul (
  input  logic                                 clk,
  input  logic signed [hpdt_pkg::MUL_A_W-1:0]  a,
  input  logic signed [hpdt_pkg::MUL_B_W-1:0]  b,
  output logic signed [hpdt_pkg::MUL_P_W-1:0]  p
);
  import hpdt_pkg::*;

  // Registered signed product
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a * b);
  end

endmodule

@@ hdl/hpdt_ctrl.sv @@
module hpdt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                out_free,
  output hpdt_pkg::hpdt_ctl_t ctl
);
  import hpdt_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: one multiply issued per step, product used the step after
  always_comb begin
    state_next    = state;
    ctl.ready     = 1'b0;
    ctl.load_err  = 1'b0;
    ctl.upd_integ = 1'b0;
    ctl.msel      = MSEL_E_DT;
    ctl.acc_op    = ACC_HOLD;
    ctl.load_s    = 1'b0;
    ctl.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        ctl.ready = 1'b1;
        if (start) state_next = ST_ERR;
      end
      ST_ERR: begin
        ctl.load_err = 1'b1;
        state_next   = ST_EDT;
      end
      ST_EDT: begin
        ctl.msel   = MSEL_E_DT;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        ctl.upd_integ = 1'b1;
        ctl.msel      = MSEL_KP_E;
        state_next    = ST_KD;
      end
      ST_KD: begin
        ctl.acc_op = ACC_LOAD_PROD;
        ctl.msel   = MSEL_KD_RATE;
        state_next = ST_KI;
      end
      ST_KI: begin
        ctl.acc_op = ACC_ADD_PROD;
        ctl.msel   = MSEL_KI_INT;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        ctl.acc_op = ACC_ADD_PROD;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        ctl.load_s = 1'b1;
        state_next = ST_KGLO;
      end
      ST_KGLO: begin
        ctl.msel   = MSEL_KG_SLO;
        state_next = ST_KGHI;
      end
      ST_KGHI: begin
        ctl.acc_op = ACC_LOAD_THRUST;
        ctl.msel   = MSEL_KG_SHI;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        ctl.acc_op = ACC_ADD_PROD_HI;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous word is still unclaimed
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/heading_pid_differential_thrust.sv @@
// Heading PID controller with differential thrust output.
//
// Channels: tick (sink) takes one control-tick word: measured heading, rate
// term, elapsed time and an optional new target. cmd (source) returns one
// word per tick: starboard and port thrust commands and the integrator
// saturation flag. The user writes gains and total thrust through cfg_we /
// cfg_index / cfg_data only while idle; the block does not enforce this.
//
// Timing: one shared 17 x 33 multiplier is stepped by a twelve-state
// sequencer. A tick word is captured, then its error, products, sums and
// clamped thrusts are worked out in order; a new tick word is taken only
// once the sequencer is back in idle. The sequencer owns the datapath, so
// tick.ready is low while a tick is being worked on.
//
// Reset (rst, synchronous) clears the stored target and the integrator, loads
// the default gains and total thrust and empties the output register.
// If cmd is stalled, the next tick is still accepted and computed; it then
// waits in its last step until the pending word has been taken.
module heading_pid_differential_thrust (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hpdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hpdt_pkg::THRUST_W-1:0]    cfg_data,
  hpdt_tick_if.sink                        tick,
  hpdt_cmd_if.source                       cmd
);
  import hpdt_pkg::*;

  localparam logic signed [ERR_W-1:0] HALF_TURN_C = ERR_W'(HALF_TURN);
  localparam logic signed [ERR_W-1:0] FULL_TURN_C = ERR_W'(FULL_TURN);
  localparam logic signed [ACC_W-1:0] LOOP_LIM_C  =
    {{(ACC_W-LOOP_LIM_BIT-1){1'b0}}, 1'b1, {LOOP_LIM_BIT{1'b0}}};
  localparam logic signed [ACC_W-1:0] LOOP_NEG_C  = -LOOP_LIM_C;
  localparam int STB_W  = ACC_W - OUT_SHIFT;
  localparam int PORT_W = STB_W + 1;
  localparam logic signed [STB_W-1:0]  STB_ONE  = STB_W'(THRUST_ONE);
  localparam logic signed [PORT_W-1:0] PORT_ONE = PORT_W'(THRUST_ONE);

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_overall;
  logic signed [GAIN_W-1:0] gain_proportional;
  logic signed [GAIN_W-1:0] gain_integral;
  logic signed [GAIN_W-1:0] gain_derivative;
  logic [THRUST_W-1:0]      thrust_sum;

  // State
  logic signed [TARGET_W-1:0]      stored_target;
  logic signed [INTEGRAL_BITS-1:0] error_integral;

  // Tick word held for the sequence
  logic signed [HEAD_W-1:0] meas;
  logic signed [15:0]       rate;
  logic [15:0]              dt;

  // Working registers
  logic signed [ERR_W-1:0] err;
  logic signed [S_W-1:0]   loop_sum;
  logic signed [ACC_W-1:0] acc;
  logic                    sat;

  hpdt_ctl_t ctl;
  logic      accept;
  logic      out_free;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ACC_W-1:0]   prod_ext;

  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_wrap;
  logic signed [SUM_W-1:0]  integ_sum;
  logic                     integ_ovf;
  logic signed [STB_W-1:0]  stb_raw;
  logic signed [PORT_W-1:0] port_raw;
  logic [CMD_W-1:0]         stb_cmd;
  logic [CMD_W-1:0]         prt_cmd;

  assign accept     = tick.valid & ctl.ready;
  assign tick.ready = ctl.ready;
  assign out_free   = ~cmd.valid | cmd.ready;

  hpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (tick.valid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  hpdt_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_overall      <= '0;
      gain_proportional <= GAIN_W'(256);
      gain_integral     <= '0;
      gain_derivative   <= '0;
      thrust_sum        <= THRUST_W'(THRUST_ONE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_OVERALL:      gain_overall      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_PROPORTIONAL: gain_proportional <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEGRAL:     gain_integral     <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIVATIVE:   gain_derivative   <= cfg_data[GAIN_W-1:0];
        REG_THRUST_SUM:        thrust_sum        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Heading error, wrapped once by a full turn
  always_comb begin
    err_raw = $signed({stored_target[TARGET_W-1], stored_target})
            - $signed({{(ERR_W-HEAD_W){meas[HEAD_W-1]}}, meas});
    if (err_raw > HALF_TURN_C) begin
      err_wrap = err_raw - FULL_TURN_C;
    end else if (err_raw < -HALF_TURN_C) begin
      err_wrap = err_raw + FULL_TURN_C;
    end else begin
      err_wrap = err_raw;
    end
  end

  // Integrator add; overflow when the top bits disagree
  always_comb begin
    integ_sum = $signed({{(SUM_W-INTEGRAL_BITS){error_integral[INTEGRAL_BITS-1]}},
                         error_integral})
              + $signed({{(SUM_W-MUL_P_W){prod[MUL_P_W-1]}}, prod});
    integ_ovf = ~((&integ_sum[SUM_W-1:INTEGRAL_BITS-1]) |
                  ~(|integ_sum[SUM_W-1:INTEGRAL_BITS-1]));
  end

  // Tick capture, target load and integrator update
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_target  <= '0;
      error_integral <= '0;
      sat            <= 1'b0;
    end else begin
      if (accept && tick.target_valid) begin
        stored_target  <= tick.target_heading;
        error_integral <= '0;
      end else if (ctl.upd_integ) begin
        sat <= integ_ovf;
        if (integ_ovf) begin
          error_integral <= integ_sum[SUM_W-1] ?
            {1'b1, {(INTEGRAL_BITS-1){1'b0}}} : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
        end else begin
          error_integral <= integ_sum[INTEGRAL_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meas <= tick.measured_heading;
      rate <= tick.rate_term;
      dt   <= tick.elapsed_time;
    end
    if (ctl.load_err) err <= err_wrap;
  end

  // Multiplier operand select
  always_comb begin
    case (ctl.msel)
      MSEL_E_DT: begin
        mul_a = $signed({1'b0, dt});
        mul_b = $signed({{(MUL_B_W-ERR_W){err[ERR_W-1]}}, err});
      end
      MSEL_KP_E: begin
        mul_a = $signed({gain_proportional[GAIN_W-1], gain_proportional});
        mul_b = $signed({{(MUL_B_W-ERR_W){err[ERR_W-1]}}, err});
      end
      MSEL_KD_RATE: begin
        mul_a = $signed({gain_derivative[GAIN_W-1], gain_derivative});
        mul_b = $signed({{(MUL_B_W-16){rate[15]}}, rate});
      end
      MSEL_KI_INT: begin
        mul_a = $signed({gain_integral[GAIN_W-1], gain_integral});
        mul_b = $signed({{(MUL_B_W-INTEGRAL_BITS+INT_SHIFT){error_integral[INTEGRAL_BITS-1]}},
                         error_integral[INTEGRAL_BITS-1:INT_SHIFT]});
      end
      MSEL_KG_SLO: begin
        mul_a = $signed({gain_overall[GAIN_W-1], gain_overall});
        mul_b = $signed({{(MUL_B_W-S_HALF){1'b0}}, loop_sum[S_HALF-1:0]});
      end
      MSEL_KG_SHI: begin
        mul_a = $signed({gain_overall[GAIN_W-1], gain_overall});
        mul_b = $signed({{(MUL_B_W-S_W+S_HALF){loop_sum[S_W-1]}}, loop_sum[S_W-1:S_HALF]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = $signed({{(ACC_W-MUL_P_W){prod[MUL_P_W-1]}}, prod});

  // Accumulator
  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      ACC_LOAD_PROD:   acc <= prod_ext;
      ACC_ADD_PROD:    acc <= acc + prod_ext;
      ACC_LOAD_THRUST: acc <= $signed({{(ACC_W-THRUST_W-8){1'b0}}, thrust_sum, 8'd0})
                            + prod_ext;
      ACC_ADD_PROD_HI: acc <= acc + (prod_ext <<< S_HALF);
      default: ;
    endcase
  end

  // Loop sum held to +/- 2^40
  always_ff @(posedge clk) begin
    if (ctl.load_s) begin
      if (acc > LOOP_LIM_C) begin
        loop_sum <= LOOP_LIM_C[S_W-1:0];
      end else if (acc < LOOP_NEG_C) begin
        loop_sum <= LOOP_NEG_C[S_W-1:0];
      end else begin
        loop_sum <= acc[S_W-1:0];
      end
    end
  end

  // Thrust split and clamping
  always_comb begin
    stb_raw  = acc[ACC_W-1:OUT_SHIFT];
    port_raw = $signed({{(PORT_W-THRUST_W){1'b0}}, thrust_sum})
             - $signed({stb_raw[STB_W-1], stb_raw});
    if (stb_raw[STB_W-1]) begin
      stb_cmd = '0;
    end else if (stb_raw > STB_ONE) begin
      stb_cmd = CMD_W'(THRUST_ONE);
    end else begin
      stb_cmd = stb_raw[CMD_W-1:0];
    end
    if (port_raw[PORT_W-1]) begin
      prt_cmd = '0;
    end else if (port_raw > PORT_ONE) begin
      prt_cmd = CMD_W'(THRUST_ONE);
    end else begin
      prt_cmd = port_raw[CMD_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else if (ctl.load_out) begin
      cmd.valid <= 1'b1;
    end else if (cmd.ready) begin
      cmd.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      cmd.starboard_cmd        <= stb_cmd;
      cmd.port_side_cmd        <= prt_cmd;
      cmd.integrator_saturated <= sat;
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import hpdt_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_TICKS   = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int END_SETTLE    = 24;

  typedef struct packed {
    logic signed [HEAD_W-1:0]   measured_heading;
    logic signed [15:0]         rate_term;
    logic        [15:0]         elapsed_time;
    logic                       target_valid;
    logic signed [TARGET_W-1:0] target_heading;
  } tick_word_t;

  typedef struct packed {
    logic [CMD_W-1:0] starboard_cmd;
    logic [CMD_W-1:0] port_side_cmd;
    logic             integrator_saturated;
  } thrust_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THRUST_W-1:0]  cfg_data;

  hpdt_tick_if tick_bus ();
  hpdt_cmd_if  cmd_bus ();

  heading_pid_differential_thrust u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_bus),
    .cmd       (cmd_bus)
  );

  // controller copy: gains, thrust, target and integrator
  longint gain_g, gain_p, gain_i, gain_d, thrust_total;
  longint hdg_target, hdg_integral;

  thrust_word_t thrust_expected [$];
  thrust_word_t want_word;

  int send_idle_pct;
  int recv_stall_pct;
  bit recv_held;
  int mismatch_count;
  int words_checked;
  int quiet_cycles;

  // clock, 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // one control tick of the heading loop, updates target and integrator
  function automatic thrust_word_t predict_thrust(input tick_word_t w);
    longint imax, imin, err, prod, loop_sum, loop_lim, stb, prt;
    thrust_word_t res;
    imax     = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
    imin     = -imax - 1;
    loop_lim = longint'(1) <<< LOOP_LIM_BIT;
    res      = '0;
    if (w.target_valid) begin
      hdg_target   = longint'($signed(w.target_heading));
      hdg_integral = 0;
    end
    // single wrap only, residual beyond half a turn is kept
    err = hdg_target - longint'($signed(w.measured_heading));
    if (err > HALF_TURN) err -= FULL_TURN;
    else if (err < -HALF_TURN) err += FULL_TURN;
    // saturating integrator
    prod = err * longint'(w.elapsed_time);
    if (prod > 0 && hdg_integral > imax - prod) begin
      hdg_integral = imax;
      res.integrator_saturated = 1'b1;
    end else if (prod < 0 && hdg_integral < imin - prod) begin
      hdg_integral = imin;
      res.integrator_saturated = 1'b1;
    end else begin
      hdg_integral += prod;
    end
    // loop sum, integral floored to 1/128 degree-second
    loop_sum = gain_p * err + gain_d * longint'($signed(w.rate_term))
             + gain_i * (hdg_integral >>> INT_SHIFT);
    if (loop_sum > loop_lim) loop_sum = loop_lim;
    else if (loop_sum < -loop_lim) loop_sum = -loop_lim;
    // thrust split, port from the unclamped starboard
    stb = (thrust_total * 256 + gain_g * loop_sum) >>> OUT_SHIFT;
    prt = thrust_total - stb;
    if (stb < 0) stb = 0;
    else if (stb > THRUST_ONE) stb = THRUST_ONE;
    if (prt < 0) prt = 0;
    else if (prt > THRUST_ONE) prt = THRUST_ONE;
    res.starboard_cmd = CMD_W'(stb);
    res.port_side_cmd = CMD_W'(prt);
    return res;
  endfunction

  function automatic tick_word_t make_tick(input int meas, input int rate, input int dt,
                                           input bit tv, input int tgt);
    tick_word_t w;
    w.measured_heading = HEAD_W'(meas);
    w.rate_term        = 16'(rate);
    w.elapsed_time     = 16'(dt);
    w.target_valid     = tv;
    w.target_heading   = TARGET_W'(tgt);
    return w;
  endfunction

  // mostly headings near the target so the loop stays out of its clamps
  function automatic tick_word_t random_tick();
    int tgt, base, meas, rate, dt, pick;
    bit tv;
    tv   = ($urandom_range(9) == 0);
    pick = $urandom_range(9);
    if (pick < 8) tgt = int'($urandom_range(92160)) - 46080;
    else tgt = int'($urandom_range(131071)) - 65536;
    base = tv ? tgt : int'(hdg_target);
    if ($urandom_range(9) < 6) meas = base + int'($urandom_range(4096)) - 2048;
    else if ($urandom_range(1)) meas = int'($urandom_range(46080)) - 23040;
    else meas = int'($urandom_range(65535)) - 32768;
    if ($urandom_range(1)) rate = int'($urandom_range(2048)) - 1024;
    else rate = int'($urandom_range(65535)) - 32768;
    pick = $urandom_range(9);
    if (pick < 5) dt = $urandom_range(13107);
    else if (pick == 5) dt = 0;
    else if (pick == 6) dt = 65535;
    else dt = $urandom_range(65535);
    return make_tick(meas, rate, dt, tv, tgt);
  endfunction

  function automatic logic signed [15:0] small_gain(input int mag);
    int v;
    v = int'($urandom_range(2 * mag)) - mag;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] extreme_gain();
    return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
  endfunction

  // offer one word, valid stays high on return
  task automatic send_tick(input tick_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tick_bus.valid            <= 1'b1;
    tick_bus.measured_heading <= w.measured_heading;
    tick_bus.rate_term        <= w.rate_term;
    tick_bus.elapsed_time     <= w.elapsed_time;
    tick_bus.target_valid     <= w.target_valid;
    tick_bus.target_heading   <= w.target_heading;
    @(posedge clk);
    while (!tick_bus.ready) @(posedge clk);
    thrust_expected.push_back(predict_thrust(w));
  endtask

  task automatic wait_for_commands_done();
    tick_bus.valid <= 1'b0;
    @(posedge clk);
    while (thrust_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // block must be idle: drain first, then write all five registers back to back
  task automatic set_gains(input logic signed [15:0] kg, input logic signed [15:0] kp,
                           input logic signed [15:0] ki, input logic signed [15:0] kd,
                           input logic [THRUST_W-1:0] total);
    cfg_reg_t          order [5];
    logic [THRUST_W-1:0] vals [5];
    order[0] = REG_GAIN_OVERALL;      vals[0] = {kg[15], kg};
    order[1] = REG_GAIN_PROPORTIONAL; vals[1] = {kp[15], kp};
    order[2] = REG_GAIN_INTEGRAL;     vals[2] = {ki[15], ki};
    order[3] = REG_GAIN_DERIVATIVE;   vals[3] = {kd[15], kd};
    order[4] = REG_THRUST_SUM;        vals[4] = total;
    wait_for_commands_done();
    for (int r = 0; r < 5; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[r];
      cfg_data  <= vals[r];
      @(posedge clk);
    end
    cfg_we       <= 1'b0;
    gain_g       = longint'(kg);
    gain_p       = longint'(kp);
    gain_i       = longint'(ki);
    gain_d       = longint'(kd);
    thrust_total = longint'(total);
  endtask

  // reset gains: overall gain zero, so both sides sit at half the total
  task automatic test_reset_defaults();
    set_pace(0, 0);
    send_tick(make_tick(0, 0, 6554, 1'b0, 0));
    send_tick(make_tick(1280, -500, 6554, 1'b0, 0));
    send_tick(make_tick(-700, 900, 65535, 1'b1, 2560));
  endtask

  task automatic test_directed_extremes();
    set_pace(0, 0);
    // integral floored before the integral gain, negative and positive
    set_gains(16'sd1, 16'sd0, 16'sd256, 16'sd0, 17'd32768);
    send_tick(make_tick(0, 0, 1, 1'b1, -1));
    send_tick(make_tick(0, 0, 0, 1'b0, 0));
    send_tick(make_tick(0, 0, 65535, 1'b1, 1));
    send_tick(make_tick(0, 0, 1, 1'b0, 0));
    // angle wrap edges and residual error past half a turn
    set_gains(16'sd1, 16'sd1, 16'sd0, 16'sd1, 17'd32768);
    send_tick(make_tick(-23040, 0, 100, 1'b1, 23040));
    send_tick(make_tick(0, 0, 100, 1'b1, 23040));
    send_tick(make_tick(0, 0, 100, 1'b1, -23040));
    send_tick(make_tick(0, 32767, 100, 1'b1, 23041));
    send_tick(make_tick(0, -32768, 100, 1'b1, -23041));
    send_tick(make_tick(-32768, 0, 100, 1'b1, 65535));
    send_tick(make_tick(32767, 0, 100, 1'b1, -65536));
    send_tick(make_tick(32767, 32767, 65535, 1'b0, 46080));
    send_tick(make_tick(-32768, -32768, 0, 1'b0, -46080));
    // loop sum limit, total thrust above two
    set_gains(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'h1ffff);
    send_tick(make_tick(-32768, 32767, 65535, 1'b1, 65535));
    send_tick(make_tick(0, -32768, 0, 1'b0, 0));
    set_gains(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 17'd0);
    send_tick(make_tick(32767, -32768, 65535, 1'b1, -65536));
    send_tick(make_tick(-32768, 32767, 65535, 1'b0, 0));
    // full total with no loop gain puts both sides exactly at one
    set_gains(16'sd0, 16'sd256, 16'sd0, 16'sd0, 17'd65536);
    send_tick(make_tick(1000, 1000, 6554, 1'b1, 0));
    send_tick(make_tick(-1000, -1000, 6554, 1'b0, 0));
  endtask

  // receiver holds off while the sender keeps offering, then all words drain and ten more are sent
  task automatic test_output_backpressure();
    set_gains(16'sd2, 16'sd64, 16'sd16, 16'sd32, 17'd40000);
    set_pace(0, 0);
    fork
      begin
        recv_held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_held = 1'b0;
      end
      repeat (20) send_tick(random_tick());
    join
    wait_for_commands_done();
    repeat (10) send_tick(random_tick());
  endtask

  task automatic test_random_ticks();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          set_pace(0, 0);
        end
        1: begin
          set_pace(83, 0);
        end
        2: begin
          set_pace(0, 83);
        end
        default: begin
          set_pace(34, 34);
        end
      endcase
      if (ph == 1) begin
        set_gains(extreme_gain(), extreme_gain(), extreme_gain(), extreme_gain(),
                  $urandom_range(1) ? 17'h1ffff : 17'd0);
      end else if (ph == 3) begin
        set_gains(small_gain(8), small_gain(512), small_gain(512), small_gain(512),
                  THRUST_W'($urandom_range(131071)));
      end else begin
        set_gains(small_gain(8), small_gain(512), small_gain(512), small_gain(512),
                  THRUST_W'($urandom_range(65536)));
      end
      repeat (PHASE_TICKS) send_tick(random_tick());
    end
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rst || recv_held) cmd_bus.ready <= 1'b0;
    else cmd_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && cmd_bus.valid && cmd_bus.ready) begin
      words_checked++;
      if (thrust_expected.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
      end else begin
        want_word = thrust_expected.pop_front();
        if (cmd_bus.starboard_cmd !== want_word.starboard_cmd)
          report_mismatch($sformatf("word %0d starboard_cmd got %0d expected %0d",
                                    words_checked, cmd_bus.starboard_cmd,
                                    want_word.starboard_cmd));
        if (cmd_bus.port_side_cmd !== want_word.port_side_cmd)
          report_mismatch($sformatf("word %0d port_side_cmd got %0d expected %0d",
                                    words_checked, cmd_bus.port_side_cmd,
                                    want_word.port_side_cmd));
        if (cmd_bus.integrator_saturated !== want_word.integrator_saturated)
          report_mismatch($sformatf("word %0d integrator_saturated got %0b expected %0b",
                                    words_checked, cmd_bus.integrator_saturated,
                                    want_word.integrator_saturated));
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (tick_bus.valid && tick_bus.ready) || (cmd_bus.valid && cmd_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("heading_pid_differential_thrust verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_index                 = REG_GAIN_OVERALL;
    cfg_data                  = '0;
    tick_bus.valid            = 1'b0;
    tick_bus.measured_heading = '0;
    tick_bus.rate_term        = '0;
    tick_bus.elapsed_time     = '0;
    tick_bus.target_valid     = 1'b0;
    tick_bus.target_heading   = '0;
    cmd_bus.ready             = 1'b0;
    recv_held                 = 1'b0;
    send_idle_pct             = 0;
    recv_stall_pct            = 0;
    mismatch_count            = 0;
    words_checked             = 0;
    quiet_cycles              = 0;
    // reset state of the controller copy
    gain_g       = 0;
    gain_p       = 256;
    gain_i       = 0;
    gain_d       = 0;
    thrust_total = 32768;
    hdg_target   = 0;
    hdg_integral = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed_extremes();
    test_output_backpressure();
    test_random_ticks();

    wait_for_commands_done();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("heading_pid_differential_thrust verification clean");
    end else begin
      $display("heading_pid_differential_thrust verification failed");
    end
    $finish;
  end

endmodule
